/* rtl/ttmm_pkg.sv */
// shared types and constants for the transposition table with max merge
`timescale 1ns / 1ps
`default_nettype none
package ttmm_pkg;

	localparam int KIND_W = 2;
	localparam int KEY_W  = 64;
	localparam int VAL_W  = 8;
	localparam int SLOT_W = 12;
	localparam int STEP_W = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_CLEAR   = 5'b00001,
		ST_IDLE    = 5'b00010,
		ST_HOME    = 5'b00100,
		ST_PROBE   = 5'b01000,
		ST_DELIVER = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_HIT   = 2'd1,
		RES_WRITE = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear_wr;
		logic     issue_home;
		logic     step;
		logic     wr_en;
		logic     wr_home;
		logic     wr_merge;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  key_zero;
		logic  mod_done;
		logic  key_empty;
		logic  key_match;
		logic  probe_last;
		logic  clear_last;
	} dp_status_t;

endpackage
`default_nettype wire

/* rtl/ttmm_ram.sv */
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ttmm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

/* rtl/ttmm_datapath.sv */
// datapath: key and value memories, probe index, home reduction, result registers
`timescale 1ns / 1ps
`default_nettype none
module ttmm_datapath #(
	parameter int TABLE_SIZE = 4096,
	parameter int MAX_PROBES = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ttmm_pkg::ctrl_cmd_t           cmd,
	output ttmm_pkg::dp_status_t               sts,
	input  wire logic [ttmm_pkg::KIND_W-1:0]   kind,
	input  wire logic [ttmm_pkg::KEY_W-1:0]    key,
	input  wire logic [ttmm_pkg::SLOT_W-1:0]   slot_index,
	input  wire logic signed [ttmm_pkg::VAL_W-1:0] first_value,
	input  wire logic signed [ttmm_pkg::VAL_W-1:0] second_value,
	output logic                               found,
	output logic      [ttmm_pkg::SLOT_W-1:0]   slot,
	output logic signed [ttmm_pkg::VAL_W-1:0]  stored_first,
	output logic signed [ttmm_pkg::VAL_W-1:0]  stored_second
);
	import ttmm_pkg::*;

	localparam int  IDX_W   = $clog2(TABLE_SIZE);
	localparam int  PW      = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
	localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
	localparam logic [IDX_W:0] TS_EXT = (IDX_W + 1)'(TABLE_SIZE);

	kind_t                    kind_q;
	logic [KEY_W-1:0]         key_q;
	logic signed [VAL_W-1:0]  v1_q;
	logic signed [VAL_W-1:0]  v2_q;
	logic [IDX_W-1:0]         home_q;
	logic [IDX_W-1:0]         idx_q;
	logic [PW-1:0]            probes_q;
	logic [IDX_W-1:0]         clr_q;
	logic                     res_found_q;
	logic [IDX_W-1:0]         res_slot_q;
	logic signed [VAL_W-1:0]  res_first_q;
	logic signed [VAL_W-1:0]  res_second_q;

	logic [IDX_W-1:0]         home_val;
	logic                     mod_done;
	logic [IDX_W:0]           next_sum;
	logic [IDX_W-1:0]         next_idx;
	logic [IDX_W-1:0]         rd_addr;
	logic [KEY_W-1:0]         key_rd;
	logic [2*VAL_W-1:0]       val_rd;
	logic signed [VAL_W-1:0]  rd_first;
	logic signed [VAL_W-1:0]  rd_second;
	logic                     key_wr_en;
	logic [IDX_W-1:0]         key_wr_addr;
	logic [KEY_W-1:0]         key_wr_data;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [VAL_W-1:0]  wr_first;
	logic signed [VAL_W-1:0]  wr_second;
	logic [IDX_W+SLOT_W-1:0]  slot_ext;

	// reduction of the key (or the update slot) modulo the table size
	generate
		if (IS_POW2) begin : g_mask
			logic [IDX_W-1:0] op_q;
			always_ff @(posedge clk) begin
				if (cmd.load) begin
					op_q <= (kind == KIND_UPDATE) ?
						IDX_W'({{(KEY_W-SLOT_W){1'b0}}, slot_index}) : key[IDX_W-1:0];
				end
			end
			assign home_val = op_q;
			assign mod_done = 1'b1;
		end else begin : g_serial
			// one key byte at a time, msb first: a reciprocal estimate of
			// the quotient digit, then one correcting subtract
			localparam int XW = IDX_W + 8;
			localparam int RW = 9;
			localparam logic [RW-1:0] RECIP    = RW'((1 << XW) / TABLE_SIZE);
			localparam logic [XW-1:0] N_X      = XW'(TABLE_SIZE);
			localparam logic [4:0]    CNT_DONE = 5'd16;
			logic [KEY_W-1:0] op_q;
			logic [IDX_W-1:0] rem_q;
			logic [XW-1:0]    x_q;
			logic [7:0]       qd_q;
			logic [4:0]       cnt_q;
			logic [XW-1:0]    x_nx;
			logic [XW+RW-1:0] prod;
			logic [XW-1:0]    qn;
			logic [XW-1:0]    r0;
			logic [XW-1:0]    r1;
			always_comb begin
				x_nx = {rem_q, op_q[KEY_W-1 -: 8]};
				prod = {{RW{1'b0}}, x_nx} * {{XW{1'b0}}, RECIP};
				qn   = {{(XW-8){1'b0}}, qd_q} * N_X;
				r0   = x_q - qn;
				r1   = (r0 >= N_X) ? r0 - N_X : r0;
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= CNT_DONE;
				end else if (cmd.load) begin
					cnt_q <= '0;
				end else if (cnt_q != CNT_DONE) begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			always_ff @(posedge clk) begin
				if (cmd.load) begin
					op_q  <= (kind == KIND_UPDATE) ? {{(KEY_W-SLOT_W){1'b0}}, slot_index} : key;
					rem_q <= '0;
				end else if (cnt_q != CNT_DONE) begin
					if (!cnt_q[0]) begin
						x_q  <= x_nx;
						qd_q <= prod[XW+7:XW];
					end else begin
						op_q  <= {op_q[KEY_W-9:0], 8'd0};
						rem_q <= r1[IDX_W-1:0];
					end
				end
			end
			assign home_val = rem_q;
			assign mod_done = (cnt_q == CNT_DONE);
		end
	endgenerate

	// next probe: step of (key & 0xff) + 1, one wrap at most
	always_comb begin
		next_sum = {1'b0, idx_q} + (IDX_W + 1)'(key_q[STEP_W-1:0]) + (IDX_W + 1)'(1);
		next_idx = (next_sum >= TS_EXT) ? IDX_W'(next_sum - TS_EXT) : next_sum[IDX_W-1:0];
	end

	always_comb begin
		if (cmd.issue_home) begin
			rd_addr = home_val;
		end else if (cmd.step) begin
			rd_addr = next_idx;
		end else begin
			rd_addr = idx_q;
		end
	end

	assign rd_first  = val_rd[2*VAL_W-1:VAL_W];
	assign rd_second = val_rd[VAL_W-1:0];

	// write values: plain replace, or on an update a max merge when the key already sits there
	always_comb begin
		wr_addr   = cmd.wr_home ? home_q : idx_q;
		wr_first  = v1_q;
		wr_second = v2_q;
		if (cmd.wr_merge) begin
			if (!(v1_q > rd_first)) begin
				wr_first = rd_first;
			end
			if (!(v2_q > rd_second)) begin
				wr_second = rd_second;
			end
		end
	end

	always_comb begin
		key_wr_en   = cmd.clear_wr | cmd.wr_en;
		key_wr_addr = cmd.clear_wr ? clr_q : wr_addr;
		key_wr_data = cmd.clear_wr ? '0 : key_q;
	end

	ttmm_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (key_wr_addr),
		.wr_data (key_wr_data),
		.rd_addr (rd_addr),
		.rd_data (key_rd)
	);

	ttmm_ram #(.WIDTH(2*VAL_W), .DEPTH(TABLE_SIZE)) u_val_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data ({wr_first, wr_second}),
		.rd_addr (rd_addr),
		.rd_data (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			key_q  <= key;
			v1_q   <= first_value;
			v2_q   <= second_value;
		end
		if (cmd.issue_home) begin
			home_q   <= home_val;
			idx_q    <= home_val;
			probes_q <= '0;
		end else if (cmd.step) begin
			idx_q    <= next_idx;
			probes_q <= probes_q + PW'(1);
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_HIT: begin
					res_found_q  <= 1'b1;
					res_slot_q   <= idx_q;
					res_first_q  <= rd_first;
					res_second_q <= rd_second;
				end
				RES_WRITE: begin
					res_found_q  <= 1'b0;
					res_slot_q   <= wr_addr;
					res_first_q  <= wr_first;
					res_second_q <= wr_second;
				end
				default: begin
					res_found_q  <= 1'b0;
					res_slot_q   <= '0;
					res_first_q  <= '0;
					res_second_q <= '0;
				end
			endcase
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, res_slot_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found         <= res_found_q;
			slot          <= slot_ext[SLOT_W-1:0];
			stored_first  <= res_first_q;
			stored_second <= res_second_q;
		end
	end

	always_comb begin
		sts.kind       = kind_q;
		sts.key_zero   = (key_q == '0);
		sts.mod_done   = mod_done;
		sts.key_empty  = (key_rd == '0);
		sts.key_match  = (key_rd == key_q);
		sts.probe_last = (probes_q == PW'(MAX_PROBES - 1));
		sts.clear_last = (clr_q == IDX_W'(TABLE_SIZE - 1));
	end

endmodule
`default_nettype wire

/* rtl/ttmm_ctrl.sv */
// controller: clearing sweep, probe sequencing and result handshake
`timescale 1ns / 1ps
`default_nettype none
module ttmm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output ttmm_pkg::ctrl_cmd_t       cmd,
	input  wire ttmm_pkg::dp_status_t sts
);
	import ttmm_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign out_free     = !out_valid_q || !result_stall;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_HOME;
				end
			end
			ST_HOME: begin
				if (sts.kind == KIND_NONE ||
					(sts.kind != KIND_LOOKUP && sts.key_zero)) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_nx     = ST_DELIVER;
				end else if (sts.mod_done) begin
					cmd.issue_home = 1'b1;
					state_nx       = ST_PROBE;
				end
			end
			ST_PROBE: begin
				case (sts.kind)
					KIND_LOOKUP: begin
						if (sts.key_empty) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_ZERO;
							state_nx     = ST_DELIVER;
						end else if (sts.key_match) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_HIT;
							state_nx     = ST_DELIVER;
						end else if (sts.probe_last) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_ZERO;
							state_nx     = ST_DELIVER;
						end else begin
							cmd.step = 1'b1;
						end
					end
					KIND_INSERT: begin
						if (sts.key_empty || sts.key_match || sts.probe_last) begin
							cmd.wr_en    = 1'b1;
							cmd.wr_home  = !(sts.key_empty || sts.key_match);
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_WRITE;
							state_nx     = ST_DELIVER;
						end else begin
							cmd.step = 1'b1;
						end
					end
					KIND_UPDATE: begin
						cmd.wr_en    = 1'b1;
						cmd.wr_merge = sts.key_match;
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_WRITE;
						state_nx     = ST_DELIVER;
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_ZERO;
						state_nx     = ST_DELIVER;
					end
				endcase
			end
			ST_DELIVER: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/transposition_table_max_merge_top.sv */
// top level of the transposition table with max merge
`timescale 1ns / 1ps
`default_nettype none
// Open-addressing hash table of TABLE_SIZE slots keyed by 64-bit keys, each
// slot holding two signed 8-bit scores. Lookup, insert and update-at-slot
// beats enter on the item channel one at a time; each gives exactly one beat
// on the result channel, which has its own output register, so a new item is
// taken while the previous result still waits. After reset the block sweeps
// the key memory to zero, one slot per cycle, and holds item_stall high
// meanwhile. A lookup or insert makes 1 to MAX_PROBES probes, one after
// another, since the key memory has one read port and gives one probe per
// cycle; an update writes at its home slot without stepping, and kind three
// or a zero key on insert or update goes straight to the result. With a
// TABLE_SIZE that is not a power of two, the home slot comes from a
// byte-serial remainder unit that lookups and nonzero-key inserts and
// updates wait on.
module transposition_table_max_merge_top #(
	parameter int TABLE_SIZE = 4096,
	parameter int MAX_PROBES = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// item channel
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [ttmm_pkg::KIND_W-1:0]         kind,
	input  wire logic [ttmm_pkg::KEY_W-1:0]          key,
	input  wire logic [ttmm_pkg::SLOT_W-1:0]         slot_index,
	input  wire logic signed [ttmm_pkg::VAL_W-1:0]   first_value,
	input  wire logic signed [ttmm_pkg::VAL_W-1:0]   second_value,
	// result channel
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic                                     found,
	output logic      [ttmm_pkg::SLOT_W-1:0]         slot,
	output logic signed [ttmm_pkg::VAL_W-1:0]        stored_first,
	output logic signed [ttmm_pkg::VAL_W-1:0]        stored_second
);
	import ttmm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// sequencer: clearing sweep, probing, result hand-off
	ttmm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts)
	);

	// memories, probe arithmetic and the result registers
	ttmm_datapath #(
		.TABLE_SIZE (TABLE_SIZE),
		.MAX_PROBES (MAX_PROBES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.key           (key),
		.slot_index    (slot_index),
		.first_value   (first_value),
		.second_value  (second_value),
		.found         (found),
		.slot          (slot),
		.stored_first  (stored_first),
		.stored_second (stored_second)
	);

	// the clearing sweep and a table write never share the key write port
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_wr && cmd.wr_en))
		else $error("clear sweep collided with a table write");

	// the output register is only reloaded once its beat has gone
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid || !result_stall))
		else $error("result beat overwritten before it was taken");

	// no probe step past the probe limit
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !sts.probe_last)
		else $error("probe sequence ran past the probe limit");

	// an accepted item never shows its result in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> !cmd.out_load)
		else $error("result loaded too early after item acceptance");

endmodule
`default_nettype wire
